FILE: src/stream_byte_reassembler_defines.svh
// Assertion macros for the stream byte reassembler.
// Used by stream_byte_reassembler; expects signals clock and reset in scope.
`ifndef STREAM_BYTE_REASSEMBLER_DEFINES_SVH
`define STREAM_BYTE_REASSEMBLER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SBR_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define SBR_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/sbr_pkg.sv
// Package for the stream byte reassembler: sizes, sequencer states, ring control.
// No dependencies; imported by sbr_ring and stream_byte_reassembler.
package sbr_pkg;

   // Reorder window in bytes (power of two, slot = low bits of the index)
   localparam int WINDOW  = 64;
   localparam int SLOT_W  = $clog2(WINDOW);
   localparam int CNT_W   = $clog2(WINDOW + 1);

   localparam int IDX_W   = 64;
   localparam int BYTE_W  = 8;
   localparam int SPACE_W = 7;
   localparam int PEND_W  = 7;

   // Stream bus payload widths
   localparam int REQ_DATA_W = 80;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_USER_W = 2;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LIMIT,
      ST_DECIDE,
      ST_SCAN,
      ST_ADVANCE,
      ST_ENDPOS,
      ST_CLOSE,
      ST_REPORT,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } sbr_state_type;

   // Control from the sequencer to the byte ring
   typedef struct packed {
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      logic [BYTE_W-1:0] wr_data;
      logic              set_en;
      logic              clr_en;
      logic [SLOT_W-1:0] flag_addr;
      logic [SLOT_W-1:0] rd_addr;
   } ring_ctrl_type;

endpackage

FILE: src/sbr_ring.sv
// Byte ring of the reassembler: byte memory with registered read, per-slot valid marks.
// Depends on sbr_pkg.
module sbr_ring (
   input  logic                  clock,
   input  logic                  reset,
   input  sbr_pkg::ring_ctrl_type ctrl,
   output logic [sbr_pkg::BYTE_W-1:0] rd_data,
   output logic                  flag_q
);
   import sbr_pkg::*;

   logic [BYTE_W-1:0] ring_mem [WINDOW];
   logic [BYTE_W-1:0] rd_data_ff;
   logic [WINDOW-1:0] valid_ff;
   logic [WINDOW-1:0] valid_in;

   // byte memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         ring_mem[ctrl.wr_addr] <= ctrl.wr_data;
      end
      rd_data_ff <= ring_mem[ctrl.rd_addr];
   end

   // valid marks, set or cleared at the flag address
   always_comb begin
      valid_in = valid_ff;
      if (ctrl.set_en) begin
         valid_in[ctrl.flag_addr] = 1'b1;
      end else if (ctrl.clr_en) begin
         valid_in[ctrl.flag_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_data = rd_data_ff;
   assign flag_q  = valid_ff[ctrl.flag_addr];

endmodule

FILE: src/stream_byte_reassembler.sv
// Top level of the stream byte reassembler: sequencer, shared 64-bit adder, output register.
// Depends on sbr_pkg, sbr_ring and stream_byte_reassembler_defines.svh.
//
//  channel | dir | tdata                                   | tuser                  | tlast
//  req_    | in  | stream_index, data_byte, out_space      | byte_present, stream_last | segment_end
//  rsp_    | out | out_byte, pending_bytes                 | out_valid, stream_closed  | run_last
//
// After acceptance an item keeps req_tready low through the limit, decide, advance,
// end-position and close states, then a report when it emits nothing, or a ring read and
// an output load per emitted byte; a run scan steps over the stored bytes slot by slot. The
// next item is taken in the idle state after that. The slot-by-slot scan and the single ring read port set this.
// Reset clears the valid marks and all stream state at once; no clearing pass.
// A stalled rsp_ holds the sequencer before its next result load only.
module stream_byte_reassembler (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [63:0] stream_index, [71:64] data_byte, [78:72] out_space, [79] zero
   input  logic [sbr_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] byte_present, [1] stream_last
   input  logic [sbr_pkg::REQ_USER_W-1:0]    req_tuser,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] out_byte, [14:8] pending_bytes, [15] zero
   output logic [sbr_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [0] out_valid, [1] stream_closed
   output logic [sbr_pkg::RSP_USER_W-1:0]    rsp_tuser,
   output logic                              rsp_tlast
);
   import sbr_pkg::*;

   `include "stream_byte_reassembler_defines.svh"

   localparam logic [PEND_W-1:0] PEND_MAX = PEND_W'(WINDOW);

   sbr_state_type state_ff, state_in;

   // captured item
   logic [IDX_W-1:0]   idx_ff;
   logic [BYTE_W-1:0]  data_ff;
   logic               present_ff, seg_end_ff, last_ff;
   logic [SPACE_W-1:0] space_ff;

   // stream state
   logic [IDX_W-1:0]  ne_ff, ne_in;
   logic [IDX_W-1:0]  end_pos_ff, end_pos_in;
   logic [IDX_W-1:0]  limit_ff, limit_in;
   logic              end_known_ff, end_known_in;
   logic              mid_ff, mid_in;
   logic              closed_ff, closed_in;
   logic [PEND_W-1:0] pending_ff, pending_in;

   // sequencer working registers
   logic [SLOT_W-1:0] ptr_ff, ptr_in;
   logic [SLOT_W-1:0] ep_ff, ep_in;
   logic [CNT_W-1:0]  emit_left_ff, emit_left_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_ovalid_ff, rsp_ovalid_in;
   logic              rsp_closed_ff, rsp_closed_in;
   logic [PEND_W-1:0] rsp_pend_ff, rsp_pend_in;
   logic              rsp_last_ff, rsp_last_in;

   // shared adder
   logic [IDX_W-1:0] add_a, add_b;
   logic [IDX_W:0]   add_sum;

   ring_ctrl_type     ring_ctrl;
   logic [BYTE_W-1:0] ring_rd_data;
   logic              ring_flag;

   logic               req_fire, out_free, load;
   logic               take, hit;
   logic [SLOT_W-1:0]  slot_s;
   logic [SPACE_W-1:0] space_clip;

   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign slot_s     = idx_ff[SLOT_W-1:0];
   assign space_clip = (space_ff > SPACE_W'(WINDOW)) ? SPACE_W'(WINDOW) : space_ff;
   assign take       = present_ff && !closed_ff && (idx_ff >= ne_ff) && (idx_ff < limit_ff);
   assign hit        = (idx_ff == ne_ff);
   assign load       = out_free && ((state_ff == ST_REPORT) || (state_ff == ST_EMIT_OUT));

   sbr_ring u_ring (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ring_ctrl),
      .rd_data (ring_rd_data),
      .flag_q  (ring_flag)
   );

   // shared adder operand select
   always_comb begin
      case (state_ff)
         ST_LIMIT: begin
            add_a = ne_ff;
            add_b = IDX_W'(space_clip);
         end
         ST_ADVANCE: begin
            add_a = ne_ff;
            add_b = IDX_W'(emit_left_ff);
         end
         ST_ENDPOS: begin
            add_a = idx_ff;
            add_b = IDX_W'(present_ff);
         end
         default: begin
            add_a = ne_ff;
            add_b = '0;
         end
      endcase
   end
   assign add_sum = {1'b0, add_a} + {1'b0, add_b};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_LIMIT;
         end
         ST_LIMIT:   state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (take && hit) state_in = ST_SCAN;
            else             state_in = ST_ADVANCE;
         end
         ST_SCAN: begin
            if (!ring_flag) state_in = ST_ADVANCE;
         end
         ST_ADVANCE: state_in = ST_ENDPOS;
         ST_ENDPOS:  state_in = ST_CLOSE;
         ST_CLOSE: begin
            if (emit_left_ff == '0) state_in = ST_REPORT;
            else                    state_in = ST_EMIT_RD;
         end
         ST_REPORT: begin
            if (out_free) state_in = ST_IDLE;
         end
         ST_EMIT_RD: state_in = ST_EMIT_OUT;
         ST_EMIT_OUT: begin
            if (out_free) begin
               if (emit_left_ff == CNT_W'(1)) state_in = ST_IDLE;
               else                           state_in = ST_EMIT_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and ring control per state
   always_comb begin
      ne_in        = ne_ff;
      end_pos_in   = end_pos_ff;
      limit_in     = limit_ff;
      end_known_in = end_known_ff;
      mid_in       = mid_ff;
      closed_in    = closed_ff;
      pending_in   = pending_ff;
      ptr_in       = ptr_ff;
      ep_in        = ep_ff;
      emit_left_in = emit_left_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_ovalid_in = rsp_ovalid_ff;
      rsp_closed_in = rsp_closed_ff;
      rsp_pend_in   = rsp_pend_ff;
      rsp_last_in   = rsp_last_ff;

      ring_ctrl           = '0;
      ring_ctrl.wr_addr   = slot_s;
      ring_ctrl.wr_data   = data_ff;
      ring_ctrl.flag_addr = slot_s;
      ring_ctrl.rd_addr   = ep_ff;

      case (state_ff)
         ST_IDLE: begin
            emit_left_in = '0;
         end
         // latch the acceptance limit on a segment's first item, saturating
         ST_LIMIT: begin
            if (!mid_ff) begin
               limit_in = add_sum[IDX_W] ? '1 : add_sum[IDX_W-1:0];
            end
            mid_in = !seg_end_ff;
         end
         // in-order byte starts a run; an early byte is stored
         ST_DECIDE: begin
            if (take) begin
               ring_ctrl.wr_en = 1'b1;
               if (hit) begin
                  if (ring_flag) begin
                     ring_ctrl.clr_en = 1'b1;
                     pending_in       = pending_ff - PEND_W'(1);
                  end
                  emit_left_in = CNT_W'(1);
                  ptr_in       = slot_s + SLOT_W'(1);
                  ep_in        = slot_s;
               end else if (!ring_flag) begin
                  ring_ctrl.set_en = 1'b1;
                  pending_in       = pending_ff + PEND_W'(1);
               end
            end
         end
         // count contiguous stored bytes, one slot per cycle
         ST_SCAN: begin
            ring_ctrl.flag_addr = ptr_ff;
            if (ring_flag) begin
               emit_left_in = emit_left_ff + CNT_W'(1);
               ptr_in       = ptr_ff + SLOT_W'(1);
            end
         end
         ST_ADVANCE: begin
            ne_in = add_sum[IDX_W-1:0];
            if (emit_left_ff != '0) begin
               pending_in = pending_ff - PEND_W'(emit_left_ff - CNT_W'(1));
            end
         end
         ST_ENDPOS: begin
            if (seg_end_ff && last_ff) begin
               end_known_in = 1'b1;
               end_pos_in   = add_sum[IDX_W-1:0];
            end
         end
         ST_CLOSE: begin
            if (end_known_ff && (ne_ff == end_pos_ff)) closed_in = 1'b1;
         end
         // single result for an item that delivers nothing
         ST_REPORT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = '0;
               rsp_ovalid_in = 1'b0;
               rsp_closed_in = closed_ff;
               rsp_pend_in   = pending_ff;
               rsp_last_in   = 1'b1;
            end
         end
         // deliver one byte of the run and free its slot
         ST_EMIT_OUT: begin
            ring_ctrl.flag_addr = ep_ff;
            if (out_free) begin
               ring_ctrl.clr_en = 1'b1;
               rsp_valid_in     = 1'b1;
               rsp_byte_in      = ring_rd_data;
               rsp_ovalid_in    = 1'b1;
               rsp_closed_in    = closed_ff;
               rsp_pend_in      = pending_ff;
               rsp_last_in      = (emit_left_ff == CNT_W'(1));
               ep_in            = ep_ff + SLOT_W'(1);
               emit_left_in     = emit_left_ff - CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ne_ff        <= '0;
         end_pos_ff   <= '0;
         limit_ff     <= '0;
         end_known_ff <= 1'b0;
         mid_ff       <= 1'b0;
         closed_ff    <= 1'b0;
         pending_ff   <= '0;
         emit_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ne_ff        <= ne_in;
         end_pos_ff   <= end_pos_in;
         limit_ff     <= limit_in;
         end_known_ff <= end_known_in;
         mid_ff       <= mid_in;
         closed_ff    <= closed_in;
         pending_ff   <= pending_in;
         emit_left_ff <= emit_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         idx_ff     <= req_tdata[63:0];
         data_ff    <= req_tdata[71:64];
         space_ff   <= req_tdata[78:72];
         present_ff <= req_tuser[0];
         last_ff    <= req_tuser[1];
         seg_end_ff <= req_tlast;
      end
      ptr_ff        <= ptr_in;
      ep_ff         <= ep_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_ovalid_ff <= rsp_ovalid_in;
      rsp_closed_ff <= rsp_closed_in;
      rsp_pend_ff   <= rsp_pend_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_pend_ff, rsp_byte_ff};
   assign rsp_tuser  = {rsp_closed_ff, rsp_ovalid_ff};
   assign rsp_tlast  = rsp_last_ff;

   `SBR_ASSERT_IMP(a_pending_bound, 1'b1, pending_ff <= PEND_MAX, "pending count above window")
   `SBR_ASSERT_NXT(a_closed_sticky, closed_ff, closed_ff, "stream closed flag dropped")
   `SBR_ASSERT_IMP(a_emit_count, (state_ff == ST_EMIT_RD) || (state_ff == ST_EMIT_OUT), emit_left_ff != '0, "emitting with empty run")
   `SBR_ASSERT_NXT(a_last_to_idle, load && rsp_last_in, state_ff == ST_IDLE, "run ended but sequencer busy")

endmodule
